// ===== src/tlpt_pkg.sv =====
package tlpt_pkg;

    // Default geometry of the table.
    localparam int OFFSET_BITS_DEF       = 12;
    localparam int SECOND_INDEX_BITS_DEF = 8;
    localparam int TOP_INDEX_BITS_DEF    = 6;
    localparam int FRAME_BITS_DEF        = 16;

    // Fixed widths of the interface fields.
    localparam int ADDR_W    = 26;
    localparam int PAGE_W    = 14;
    localparam int SPARE_W   = 16;
    localparam int PADDR_W   = 28;
    localparam int STATUS_W  = 2;
    localparam int HIT_W     = 32;
    localparam int MAPPED_W  = 15;
    localparam int TBYTES_W  = 18;
    localparam int TCOUNT_W  = 7;
    localparam int PTE_W     = 4;

    // Entry size register value after reset.
    localparam logic [PTE_W-1:0] PTE_RESET = 4'd4;

    // Request kinds.
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_TOUCH     = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOMEM    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNMAPPED = 2'd3;

    // Depth of the queue between front and back (a power of two).
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== src/tlpt_front.sv =====
module tlpt_front import tlpt_pkg::*; #(
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF,
    parameter int SECOND_INDEX_BITS = SECOND_INDEX_BITS_DEF,
    parameter int TOP_INDEX_BITS    = TOP_INDEX_BITS_DEF,
    parameter int FRAME_BITS        = FRAME_BITS_DEF
) (
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         req_type,
    input  logic [ADDR_W-1:0]            logical_address,
    input  logic [PAGE_W-1:0]            logical_page,
    input  logic [SPARE_W-1:0]           spare_frame,
    input  logic                         spare_frame_valid,
    input  logic                         q_full,
    input  logic                         clearing,
    output logic                         push,
    output logic                         item_kind,
    output logic                         item_frame_valid,
    output logic [FRAME_BITS-1:0]        item_frame,
    output logic [TOP_INDEX_BITS-1:0]    item_top,
    output logic [SECOND_INDEX_BITS-1:0] item_second,
    output logic [OFFSET_BITS-1:0]       item_offset
);

    // Hold off new items during the table clearing pass or while the queue is full.
    assign in_stall = clearing || q_full;
    assign push     = in_valid && !in_stall;

    // Split the request into table indexes; a touch names the page directly.
    always_comb
    begin
        item_kind        = req_type;
        item_frame_valid = spare_frame_valid;
        item_frame       = FRAME_BITS'(spare_frame);
        if (req_type == REQ_TOUCH)
        begin
            item_top    = TOP_INDEX_BITS'(logical_page >> SECOND_INDEX_BITS);
            item_second = SECOND_INDEX_BITS'(logical_page);
            item_offset = '0;
        end
        else
        begin
            item_top    = TOP_INDEX_BITS'(logical_address >> (OFFSET_BITS + SECOND_INDEX_BITS));
            item_second = SECOND_INDEX_BITS'(logical_address >> OFFSET_BITS);
            item_offset = logical_address[OFFSET_BITS-1:0];
        end
    end

endmodule

// ===== src/tlpt_queue.sv =====
module tlpt_queue import tlpt_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0]  slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full     = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops; callers never push when full or pop when empty.
    always_comb
    begin
        count_next = count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Queue storage carries payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/tlpt_back.sv =====
module tlpt_back import tlpt_pkg::*; #(
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF,
    parameter int SECOND_INDEX_BITS = SECOND_INDEX_BITS_DEF,
    parameter int TOP_INDEX_BITS    = TOP_INDEX_BITS_DEF,
    parameter int FRAME_BITS        = FRAME_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [PTE_W-1:0]             pte_bytes,
    output logic                         clearing,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  logic                         q_kind,
    input  logic                         q_frame_valid,
    input  logic [FRAME_BITS-1:0]        q_frame,
    input  logic [TOP_INDEX_BITS-1:0]    q_top,
    input  logic [SECOND_INDEX_BITS-1:0] q_second,
    input  logic [OFFSET_BITS-1:0]       q_offset,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [STATUS_W-1:0]          status,
    output logic [PADDR_W-1:0]           physical_address,
    output logic                         frame_taken,
    output logic [HIT_W-1:0]             hit_total,
    output logic [HIT_W-1:0]             miss_total,
    output logic [MAPPED_W-1:0]          mapped_pages,
    output logic [TBYTES_W-1:0]          table_bytes
);

    localparam int IDX_W     = TOP_INDEX_BITS + SECOND_INDEX_BITS;
    localparam int DEPTH     = 1 << IDX_W;
    localparam int TOP_COUNT = 1 << TOP_INDEX_BITS;
    localparam int WORD_W    = FRAME_BITS + 1;
    localparam int SUM_W     = FRAME_BITS + OFFSET_BITS + 1;
    localparam int PROD_W    = PTE_W + TCOUNT_W;
    localparam int FP_A      = PTE_W + TOP_INDEX_BITS;
    localparam int FP_B      = PROD_W + SECOND_INDEX_BITS;
    localparam int FP_AB     = (FP_A > FP_B) ? FP_A : FP_B;
    localparam int FP_W      = ((FP_AB > TBYTES_W) ? FP_AB : TBYTES_W) + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0]                   state_reg;
    logic [1:0]                   state_next;
    logic [IDX_W-1:0]             clr_idx_reg;

    // Table memory: one word per entry holding a valid bit over the frame number.
    logic [WORD_W-1:0]            mem [DEPTH];
    logic [WORD_W-1:0]            rd_word_reg;
    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic [WORD_W-1:0]            mem_wdata;
    logic                         mem_re;

    // Item under work.
    logic                         it_kind_reg;
    logic                         it_fv_reg;
    logic [FRAME_BITS-1:0]        it_frame_reg;
    logic [TOP_INDEX_BITS-1:0]    it_top_reg;
    logic [SECOND_INDEX_BITS-1:0] it_second_reg;
    logic [OFFSET_BITS-1:0]       it_offset_reg;

    // Second-level table presence, one flop per table.
    logic [TOP_COUNT-1:0]         present_reg;

    logic [HIT_W-1:0]             hit_cnt_reg;
    logic [HIT_W-1:0]             miss_cnt_reg;
    logic [MAPPED_W-1:0]          mapped_reg;
    logic [TCOUNT_W-1:0]          tables_reg;

    logic                         out_valid_reg;
    logic [STATUS_W-1:0]          status_reg;
    logic [PADDR_W-1:0]           paddr_reg;
    logic                         taken_reg;

    logic                         out_free;
    logic                         exec;
    logic                         hit;
    logic                         do_map;
    logic [STATUS_W-1:0]          res_status;
    logic [PADDR_W-1:0]           res_paddr;
    logic [SUM_W-1:0]             paddr_sum;
    logic [PROD_W-1:0]            tbl_prod;
    logic [FP_W-1:0]              fp_sum;

    assign clearing = (state_reg == S_CLEAR);
    assign out_free = !out_valid_reg || !out_stall;
    assign exec     = (state_reg == S_EXEC) && out_free;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign mem_re   = q_pop;

    // Sequencer: clearing pass after reset, then a read step and an update step per item.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_idx_reg == {IDX_W{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Lookup result and the decision for the item under work.
    assign hit       = present_reg[it_top_reg] && rd_word_reg[FRAME_BITS];
    assign paddr_sum = (SUM_W'(rd_word_reg[FRAME_BITS-1:0]) << OFFSET_BITS)
                       + SUM_W'(it_offset_reg);

    always_comb
    begin
        res_status = ST_HIT;
        res_paddr  = '0;
        do_map     = 1'b0;
        if (it_kind_reg == REQ_TRANSLATE)
        begin
            if (hit)
            begin
                res_paddr = PADDR_W'(paddr_sum);
            end
            else
            begin
                res_status = ST_UNMAPPED;
            end
        end
        else if (!hit)
        begin
            if (it_fv_reg)
            begin
                res_status = ST_MISS;
                do_map     = 1'b1;
            end
            else
            begin
                res_status = ST_NOMEM;
            end
        end
    end

    // Single write port shared by the clearing pass and the mapping of a miss.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_idx_reg;
        mem_wdata = '0;
        if (state_reg == S_CLEAR)
        begin
            mem_we = 1'b1;
        end
        else if (exec && do_map)
        begin
            mem_we    = 1'b1;
            mem_waddr = {it_top_reg, it_second_reg};
            mem_wdata = {1'b1, it_frame_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[{q_top, q_second}];
        end
    end

    // Capture the popped item alongside its table read.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            it_kind_reg   <= q_kind;
            it_fv_reg     <= q_frame_valid;
            it_frame_reg  <= q_frame;
            it_top_reg    <= q_top;
            it_second_reg <= q_second;
            it_offset_reg <= q_offset;
        end
        if (exec)
        begin
            status_reg <= res_status;
            paddr_reg  <= res_paddr;
            taken_reg  <= do_map;
        end
    end

    // Control state, presence flags and saturating counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            present_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            mapped_reg    <= '0;
            tables_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (exec && (it_kind_reg == REQ_TOUCH) && hit && (hit_cnt_reg != {HIT_W{1'b1}}))
            begin
                hit_cnt_reg <= hit_cnt_reg + 1'b1;
            end
            if (exec && do_map)
            begin
                present_reg[it_top_reg] <= 1'b1;
                if (!present_reg[it_top_reg] && (tables_reg != {TCOUNT_W{1'b1}}))
                begin
                    tables_reg <= tables_reg + 1'b1;
                end
                if (mapped_reg != {MAPPED_W{1'b1}})
                begin
                    mapped_reg <= mapped_reg + 1'b1;
                end
                if (miss_cnt_reg != {HIT_W{1'b1}})
                begin
                    miss_cnt_reg <= miss_cnt_reg + 1'b1;
                end
            end
        end
    end

    // Table footprint follows the counters, which only change when a result is loaded.
    assign tbl_prod = PROD_W'(pte_bytes) * PROD_W'(tables_reg);
    assign fp_sum   = (FP_W'(pte_bytes) << TOP_INDEX_BITS)
                      + (FP_W'(tbl_prod) << SECOND_INDEX_BITS);

    always_comb
    begin
        if (tables_reg == '0)
        begin
            table_bytes = '0;
        end
        else if (fp_sum > FP_W'({TBYTES_W{1'b1}}))
        begin
            table_bytes = {TBYTES_W{1'b1}};
        end
        else
        begin
            table_bytes = TBYTES_W'(fp_sum);
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign physical_address = paddr_reg;
    assign frame_taken      = taken_reg;
    assign hit_total        = hit_cnt_reg;
    assign miss_total       = miss_cnt_reg;
    assign mapped_pages     = mapped_reg;

endmodule

// ===== src/two_level_page_table_unit.sv =====
// Two-level page table for one task. A translate request returns the frame base plus page
// offset or a not-mapped status; a touch request counts a hit, maps the offered spare frame
// or reports no memory when none is offered. The input side takes one item per cycle while
// its two-entry queue has room; the table engine works on one item at a time, a registered
// table memory read and then the read-modify-write of the entry and counters, and takes the
// next item only once the result is loaded, which a stalled output holds off. After reset
// the table memory is swept clear, one entry a cycle, over all 2^(TOP_INDEX_BITS +
// SECOND_INDEX_BITS) entries (16384 by default); in_stall stays high until the sweep ends,
// while configuration writes are taken at any time. Write pte_bytes only while idle.
module two_level_page_table_unit import tlpt_pkg::*; #(
    parameter int OFFSET_BITS       = OFFSET_BITS_DEF,
    parameter int SECOND_INDEX_BITS = SECOND_INDEX_BITS_DEF,
    parameter int TOP_INDEX_BITS    = TOP_INDEX_BITS_DEF,
    parameter int FRAME_BITS        = FRAME_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PTE_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic [ADDR_W-1:0]   logical_address,
    input  logic [PAGE_W-1:0]   logical_page,
    input  logic [SPARE_W-1:0]  spare_frame,
    input  logic                spare_frame_valid,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [PADDR_W-1:0]  physical_address,
    output logic                frame_taken,
    output logic [HIT_W-1:0]    hit_total,
    output logic [HIT_W-1:0]    miss_total,
    output logic [MAPPED_W-1:0] mapped_pages,
    output logic [TBYTES_W-1:0] table_bytes
);

    localparam int ITEM_W = 2 + FRAME_BITS + TOP_INDEX_BITS + SECOND_INDEX_BITS + OFFSET_BITS;

    logic [PTE_W-1:0]             pte_bytes_reg;
    logic                         clearing;
    logic                         q_full;
    logic                         q_empty;
    logic                         q_pop;
    logic                         push;
    logic [ITEM_W-1:0]            push_data;
    logic [ITEM_W-1:0]            pop_data;

    logic                         f_kind;
    logic                         f_frame_valid;
    logic [FRAME_BITS-1:0]        f_frame;
    logic [TOP_INDEX_BITS-1:0]    f_top;
    logic [SECOND_INDEX_BITS-1:0] f_second;
    logic [OFFSET_BITS-1:0]       f_offset;

    logic                         b_kind;
    logic                         b_frame_valid;
    logic [FRAME_BITS-1:0]        b_frame;
    logic [TOP_INDEX_BITS-1:0]    b_top;
    logic [SECOND_INDEX_BITS-1:0] b_second;
    logic [OFFSET_BITS-1:0]       b_offset;

    // Entry size register; every transfer on the configuration channel writes it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pte_bytes_reg <= PTE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pte_bytes_reg <= cfg_data;
        end
    end

    tlpt_front #(
        .OFFSET_BITS       (OFFSET_BITS),
        .SECOND_INDEX_BITS (SECOND_INDEX_BITS),
        .TOP_INDEX_BITS    (TOP_INDEX_BITS),
        .FRAME_BITS        (FRAME_BITS)
    ) u_front (
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .req_type          (req_type),
        .logical_address   (logical_address),
        .logical_page      (logical_page),
        .spare_frame       (spare_frame),
        .spare_frame_valid (spare_frame_valid),
        .q_full            (q_full),
        .clearing          (clearing),
        .push              (push),
        .item_kind         (f_kind),
        .item_frame_valid  (f_frame_valid),
        .item_frame        (f_frame),
        .item_top          (f_top),
        .item_second       (f_second),
        .item_offset       (f_offset)
    );

    // Queue entry layout shared by both sides.
    assign push_data = {f_kind, f_frame_valid, f_frame, f_top, f_second, f_offset};
    assign {b_kind, b_frame_valid, b_frame, b_top, b_second, b_offset} = pop_data;

    tlpt_queue #(
        .WIDTH (ITEM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    tlpt_back #(
        .OFFSET_BITS       (OFFSET_BITS),
        .SECOND_INDEX_BITS (SECOND_INDEX_BITS),
        .TOP_INDEX_BITS    (TOP_INDEX_BITS),
        .FRAME_BITS        (FRAME_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pte_bytes        (pte_bytes_reg),
        .clearing         (clearing),
        .q_empty          (q_empty),
        .q_pop            (q_pop),
        .q_kind           (b_kind),
        .q_frame_valid    (b_frame_valid),
        .q_frame          (b_frame),
        .q_top            (b_top),
        .q_second         (b_second),
        .q_offset         (b_offset),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .physical_address (physical_address),
        .frame_taken      (frame_taken),
        .hit_total        (hit_total),
        .miss_total       (miss_total),
        .mapped_pages     (mapped_pages),
        .table_bytes      (table_bytes)
    );

endmodule
